[rtl/tcs_pkg.sv]
`default_nettype none

package tcs_pkg;

    localparam logic [2:0] FUNC_PUT    = 3'd0;
    localparam logic [2:0] FUNC_FOLLOW = 3'd1;
    localparam logic [2:0] FUNC_UP     = 3'd2;
    localparam logic [2:0] FUNC_DOWN   = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FIRST = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam int          TAB_STOP   = 8;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  char_code;
        logic [3:0]  bg_color;
        logic [3:0]  fg_color;
        logic [15:0] line_offset;
        logic [10:0] cell_index;
    } item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [13:0] cursor_position;
        logic [6:0]  view_top_line;
    } result_t;

    typedef enum logic {
        ROW_ADD,
        ROW_SUB
    } row_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT,
        ST_PC_WRITE,
        ST_ROW_CLEAR,
        ST_REF_INIT,
        ST_REF_COPY,
        ST_CURSOR,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/tcs_addr_unit.sv]
`default_nettype none

// row (ring add or plain subtract) then row * COLS + col, two register stages
module tcs_addr_unit #(
    parameter int COLS        = 80,
    parameter int BUFFER_ROWS = 128,
    localparam int RW = $clog2(BUFFER_ROWS),
    localparam int CW = $clog2(COLS),
    localparam int AW = $clog2(BUFFER_ROWS * COLS)
) (
    input  wire logic             clk,
    input  wire tcs_pkg::row_op_t op,
    input  wire logic [RW-1:0]    row_a,
    input  wire logic [RW-1:0]    row_b,
    input  wire logic [CW-1:0]    col,
    output logic      [AW-1:0]    addr
);

    logic [RW:0]   sum;
    logic [RW-1:0] row_next;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    always_comb
    begin
        if (op == tcs_pkg::ROW_SUB)
        begin
            sum      = {1'b0, row_a} - {1'b0, row_b};
            row_next = sum[RW-1:0];
        end
        else
        begin
            sum = {1'b0, row_a} + {1'b0, row_b};
            if (sum >= (RW+1)'(BUFFER_ROWS))
            begin
                row_next = RW'(sum - (RW+1)'(BUFFER_ROWS));
            end
            else
            begin
                row_next = sum[RW-1:0];
            end
        end
        addr_next = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col;
        addr_reg <= addr_next;
    end

    assign addr = addr_reg;

endmodule

`default_nettype wire

[rtl/tcs_ram.sv]
`default_nettype none

module tcs_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/tcs_ctrl.sv]
`default_nettype none

module tcs_ctrl #(
    parameter int COLS        = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int BUFFER_ROWS = 128,
    localparam int RW  = $clog2(BUFFER_ROWS),
    localparam int CW  = $clog2(COLS),
    localparam int CW1 = $clog2(COLS + tcs_pkg::TAB_STOP),
    localparam int SBN = BUFFER_ROWS * COLS,
    localparam int SC  = SCREEN_ROWS * COLS,
    localparam int AW  = $clog2(SBN),
    localparam int SAW = $clog2(SC),
    localparam int CLN = (SBN > SC) ? SBN : SC,
    localparam int CLW = $clog2(CLN),
    localparam int SRW = $clog2(SCREEN_ROWS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire tcs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output tcs_pkg::result_t      result,
    output tcs_pkg::row_op_t      unit_op,
    output logic      [RW-1:0]    unit_row_a,
    output logic      [RW-1:0]    unit_row_b,
    output logic      [CW-1:0]    unit_col,
    input  wire logic [AW-1:0]    unit_addr,
    output logic                  sb_we,
    output logic      [AW-1:0]    sb_waddr,
    output logic      [15:0]      sb_wdata,
    output logic      [AW-1:0]    sb_raddr,
    input  wire logic [15:0]      sb_rdata,
    output logic                  sc_we,
    output logic      [SAW-1:0]   sc_waddr,
    output logic      [15:0]      sc_wdata,
    output logic      [SAW-1:0]   sc_raddr,
    input  wire logic [15:0]      sc_rdata
);

    tcs_pkg::state_t  state_reg, state_next;
    tcs_pkg::state_t  ret_reg, ret_next;
    logic             wait_reg, wait_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RW-1:0]    top_reg, top_next;
    logic [RW-1:0]    base_reg, base_next;
    logic [13:0]      cursor_reg, cursor_next;
    logic             scroll_reg, scroll_next;
    logic [CLW-1:0]   cnt_reg, cnt_next;
    logic             wv_reg, wv_next;
    logic             out_valid_reg, out_valid_next;

    tcs_pkg::row_op_t op_reg, op_next;
    logic [RW-1:0]    ra_reg, ra_next;
    logic [RW-1:0]    rb_reg, rb_next;
    logic [CW-1:0]    ocol_reg, ocol_next;
    logic [15:0]      char_reg, char_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [SAW-1:0]   k_reg, k_next;
    logic [SRW-1:0]   r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [SRW-1:0]   rows_reg, rows_next;
    logic [SAW-1:0]   wk_reg, wk_next;
    logic             wcopy_reg, wcopy_next;
    logic [15:0]      cell_reg, cell_next;
    logic             inrange_reg, inrange_next;
    tcs_pkg::result_t out_reg, out_next;

    logic [CW1-1:0]   ncol;
    logic [RW:0]      nrow;
    logic             printable;
    logic             scroll;
    logic [16:0]      row17, top17, off17, tnew, rnum;
    logic [AW+13:0]   cur_ext;
    logic [RW+6:0]    top_ext;
    logic [SAW+10:0]  idx_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcs_pkg::ST_CLEAR;
            ret_reg       <= tcs_pkg::ST_IDLE;
            wait_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            base_reg      <= '0;
            cursor_reg    <= '0;
            scroll_reg    <= 1'b0;
            cnt_reg       <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            wait_reg      <= wait_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            base_reg      <= base_next;
            cursor_reg    <= cursor_next;
            scroll_reg    <= scroll_next;
            cnt_reg       <= cnt_next;
            wv_reg        <= wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        ocol_reg    <= ocol_next;
        char_reg    <= char_next;
        src_reg     <= src_next;
        k_reg       <= k_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        rows_reg    <= rows_next;
        wk_reg      <= wk_next;
        wcopy_reg   <= wcopy_next;
        cell_reg    <= cell_next;
        inrange_reg <= inrange_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        wait_next      = wait_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        base_next      = base_reg;
        cursor_next    = cursor_reg;
        scroll_next    = scroll_reg;
        cnt_next       = cnt_reg;
        wv_next        = 1'b0;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        ocol_next      = ocol_reg;
        char_next      = char_reg;
        src_next       = src_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        rows_next      = rows_reg;
        wk_next        = wk_reg;
        wcopy_next     = wcopy_reg;
        cell_next      = cell_reg;
        inrange_next   = inrange_reg;
        out_next       = out_reg;

        item_ready = 1'b0;
        sb_we      = 1'b0;
        sb_waddr   = cnt_reg[AW-1:0];
        sb_wdata   = tcs_pkg::BLANK_CELL;

        ncol      = CW1'(col_reg);
        nrow      = {1'b0, row_reg};
        printable = (item.char_code >= tcs_pkg::CH_FIRST) &&
                    (item.char_code <= tcs_pkg::CH_LAST);
        scroll    = 1'b0;
        row17     = 17'(row_reg);
        top17     = 17'(top_reg);
        off17     = 17'(item.line_offset);
        tnew      = top17;
        rnum      = '0;
        cur_ext   = (AW+14)'(unit_addr);
        top_ext   = (RW+7)'(top_reg);

        if (result_valid && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tcs_pkg::ST_CLEAR:
            begin
                sb_we    = (cnt_reg < CLW'(SBN));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CLW'(CLN - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcs_pkg::ST_IDLE;
                end
            end

            tcs_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cell_next = '0;
                    op_next   = tcs_pkg::ROW_ADD;
                    ra_next   = base_reg;
                    wait_next = 1'b1;
                    case (item.func) inside
                        tcs_pkg::FUNC_PUT:
                        begin
                            char_next = {item.bg_color, item.fg_color, item.char_code};
                            rb_next   = row_reg;
                            ocol_next = col_reg;
                            if (item.char_code == tcs_pkg::CH_BS && col_reg != '0)
                            begin
                                ncol = ncol - 1'b1;
                            end
                            else if (item.char_code == tcs_pkg::CH_TAB)
                            begin
                                ncol = (ncol + CW1'(tcs_pkg::TAB_STOP)) &
                                       ~CW1'(tcs_pkg::TAB_STOP - 1);
                            end
                            else if (item.char_code == tcs_pkg::CH_CR)
                            begin
                                ncol = '0;
                            end
                            else if (item.char_code == tcs_pkg::CH_LF)
                            begin
                                ncol = '0;
                                nrow = nrow + 1'b1;
                            end
                            else if (printable)
                            begin
                                ncol = ncol + 1'b1;
                            end
                            if (ncol >= CW1'(COLS))
                            begin
                                ncol = '0;
                                nrow = nrow + 1'b1;
                            end
                            scroll = (nrow >= (RW+1)'(BUFFER_ROWS - 1));
                            if (scroll)
                            begin
                                nrow      = (RW+1)'(BUFFER_ROWS - 2);
                                base_next = (base_reg == RW'(BUFFER_ROWS - 1)) ?
                                            '0 : base_reg + 1'b1;
                            end
                            col_next    = ncol[CW-1:0];
                            row_next    = nrow[RW-1:0];
                            scroll_next = scroll;
                            if (printable)
                            begin
                                ret_next   = tcs_pkg::ST_PC_WRITE;
                                state_next = tcs_pkg::ST_WAIT;
                            end
                            else if (scroll)
                            begin
                                ra_next    = base_next;
                                rb_next    = RW'(BUFFER_ROWS - 1);
                                ocol_next  = '0;
                                ret_next   = tcs_pkg::ST_ROW_CLEAR;
                                state_next = tcs_pkg::ST_WAIT;
                            end
                            else
                            begin
                                state_next = tcs_pkg::ST_DONE;
                            end
                        end

                        tcs_pkg::FUNC_FOLLOW, tcs_pkg::FUNC_UP, tcs_pkg::FUNC_DOWN:
                        begin
                            if (item.func == tcs_pkg::FUNC_FOLLOW)
                            begin
                                tnew = (row17 >= 17'(SCREEN_ROWS - 1)) ?
                                       row17 - 17'(SCREEN_ROWS - 1) : '0;
                            end
                            else if (item.func == tcs_pkg::FUNC_UP)
                            begin
                                tnew = (top17 >= off17) ? top17 - off17 : '0;
                            end
                            else
                            begin
                                tnew = (top17 + off17 < row17) ? top17 + off17 : row17;
                            end
                            rnum       = row17 + 17'd1 - tnew;
                            rows_next  = (rnum >= 17'(SCREEN_ROWS)) ?
                                         SRW'(SCREEN_ROWS) : rnum[SRW-1:0];
                            top_next   = tnew[RW-1:0];
                            rb_next    = tnew[RW-1:0];
                            ocol_next  = '0;
                            ret_next   = tcs_pkg::ST_REF_INIT;
                            state_next = tcs_pkg::ST_WAIT;
                        end

                        tcs_pkg::FUNC_READ:
                        begin
                            inrange_next = (17'(item.cell_index) < 17'(SC));
                            state_next   = tcs_pkg::ST_READ;
                        end

                        default:
                        begin
                            state_next = tcs_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            tcs_pkg::ST_WAIT:
            begin
                wait_next = 1'b0;
                if (!wait_reg)
                begin
                    state_next = ret_reg;
                end
            end

            tcs_pkg::ST_PC_WRITE:
            begin
                sb_we    = 1'b1;
                sb_waddr = unit_addr;
                sb_wdata = char_reg;
                if (scroll_reg)
                begin
                    op_next    = tcs_pkg::ROW_ADD;
                    ra_next    = base_reg;
                    rb_next    = RW'(BUFFER_ROWS - 1);
                    ocol_next  = '0;
                    wait_next  = 1'b1;
                    ret_next   = tcs_pkg::ST_ROW_CLEAR;
                    state_next = tcs_pkg::ST_WAIT;
                end
                else
                begin
                    state_next = tcs_pkg::ST_DONE;
                end
            end

            tcs_pkg::ST_ROW_CLEAR:
            begin
                sb_we    = 1'b1;
                sb_waddr = unit_addr + AW'(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CLW'(COLS - 1))
                begin
                    cnt_next    = '0;
                    scroll_next = 1'b0;
                    state_next  = tcs_pkg::ST_DONE;
                end
            end

            tcs_pkg::ST_REF_INIT:
            begin
                src_next   = unit_addr;
                k_next     = '0;
                r_next     = '0;
                c_next     = '0;
                state_next = tcs_pkg::ST_REF_COPY;
            end

            tcs_pkg::ST_REF_COPY:
            begin
                wv_next    = 1'b1;
                wk_next    = k_reg;
                wcopy_next = (r_reg < rows_reg);
                src_next   = (src_reg == AW'(SBN - 1)) ? '0 : src_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                if (c_reg == CW'(COLS - 1))
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
                if (k_reg == SAW'(SC - 1))
                begin
                    op_next    = tcs_pkg::ROW_SUB;
                    ra_next    = row_reg;
                    rb_next    = top_reg;
                    ocol_next  = col_reg;
                    wait_next  = 1'b1;
                    ret_next   = tcs_pkg::ST_CURSOR;
                    state_next = tcs_pkg::ST_WAIT;
                end
            end

            tcs_pkg::ST_CURSOR:
            begin
                cursor_next = cur_ext[13:0];
                state_next  = tcs_pkg::ST_DONE;
            end

            tcs_pkg::ST_READ:
            begin
                cell_next  = inrange_reg ? sc_rdata : '0;
                state_next = tcs_pkg::ST_DONE;
            end

            tcs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.cell_value      = cell_reg;
                    out_next.cursor_position = cursor_reg;
                    out_next.view_top_line   = top_ext[6:0];
                    out_valid_next           = 1'b1;
                    state_next               = tcs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign idx_ext  = (SAW+11)'(item.cell_index);
    assign sc_raddr = idx_ext[SAW-1:0];
    assign sb_raddr = src_reg;

    always_comb
    begin
        if (state_reg == tcs_pkg::ST_CLEAR)
        begin
            sc_we    = (cnt_reg < CLW'(SC));
            sc_waddr = cnt_reg[SAW-1:0];
            sc_wdata = tcs_pkg::BLANK_CELL;
        end
        else
        begin
            sc_we    = wv_reg;
            sc_waddr = wk_reg;
            sc_wdata = wcopy_reg ? sb_rdata : tcs_pkg::BLANK_CELL;
        end
    end

    assign unit_op      = op_reg;
    assign unit_row_a   = ra_reg;
    assign unit_row_b   = rb_reg;
    assign unit_col     = ocol_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

[rtl/text_console_scrollback_core.sv]
// Text console with a COLS x BUFFER_ROWS scrollback memory, kept as a ring of rows, and a
// COLS x SCREEN_ROWS screen memory. After reset a clearing pass writes blanks to both memories;
// no beat is taken meanwhile. One beat is handled at a time, each giving one result beat. Row
// addresses and the cursor position run through one shared row * COLS + column unit. put_char
// writes a stored character to the scrollback at the unit's address; when the buffer scrolls,
// for a control byte too, its new last row is blanked. Follow, view up and view down copy the
// whole screen one cell per cycle. A cell read returns the registered screen memory output.
// The result register lets the next beat in while a result is still pending.
`default_nettype none

module text_console_scrollback_core #(
    parameter int COLS        = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int BUFFER_ROWS = 128
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire tcs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output tcs_pkg::result_t      result
);

    localparam int RW  = $clog2(BUFFER_ROWS);
    localparam int CW  = $clog2(COLS);
    localparam int AW  = $clog2(BUFFER_ROWS * COLS);
    localparam int SAW = $clog2(SCREEN_ROWS * COLS);

    tcs_pkg::row_op_t unit_op;
    logic [RW-1:0]    unit_row_a;
    logic [RW-1:0]    unit_row_b;
    logic [CW-1:0]    unit_col;
    logic [AW-1:0]    unit_addr;
    logic             sb_we;
    logic [AW-1:0]    sb_waddr;
    logic [15:0]      sb_wdata;
    logic [AW-1:0]    sb_raddr;
    logic [15:0]      sb_rdata;
    logic             sc_we;
    logic [SAW-1:0]   sc_waddr;
    logic [15:0]      sc_wdata;
    logic [SAW-1:0]   sc_raddr;
    logic [15:0]      sc_rdata;

    tcs_ctrl #(
        .COLS        (COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .BUFFER_ROWS (BUFFER_ROWS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .unit_op      (unit_op),
        .unit_row_a   (unit_row_a),
        .unit_row_b   (unit_row_b),
        .unit_col     (unit_col),
        .unit_addr    (unit_addr),
        .sb_we        (sb_we),
        .sb_waddr     (sb_waddr),
        .sb_wdata     (sb_wdata),
        .sb_raddr     (sb_raddr),
        .sb_rdata     (sb_rdata),
        .sc_we        (sc_we),
        .sc_waddr     (sc_waddr),
        .sc_wdata     (sc_wdata),
        .sc_raddr     (sc_raddr),
        .sc_rdata     (sc_rdata)
    );

    tcs_addr_unit #(
        .COLS        (COLS),
        .BUFFER_ROWS (BUFFER_ROWS)
    ) u_addr (
        .clk   (clk),
        .op    (unit_op),
        .row_a (unit_row_a),
        .row_b (unit_row_b),
        .col   (unit_col),
        .addr  (unit_addr)
    );

    tcs_ram #(
        .DEPTH (BUFFER_ROWS * COLS),
        .WIDTH (16)
    ) u_scrollback (
        .clk   (clk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .raddr (sb_raddr),
        .rdata (sb_rdata)
    );

    tcs_ram #(
        .DEPTH (SCREEN_ROWS * COLS),
        .WIDTH (16)
    ) u_screen (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

endmodule

`default_nettype wire

[rtl/tcs_checker.sv]
`default_nettype none

module tcs_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire tcs_pkg::result_t result
);

    // stalled result beat holds its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // busy after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accept");

    // no result appears in the cycle after a beat is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
        else $error("result too early");

endmodule

bind text_console_scrollback_core tcs_checker u_tcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int COLS        = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int BUFFER_ROWS = 128;
    localparam int WATCHDOG    = 60000;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    tcs_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    tcs_pkg::result_t result;

    logic [15:0] sb_mem [0:BUFFER_ROWS*COLS-1];
    logic [15:0] scr_mem [0:SCREEN_ROWS*COLS-1];
    logic [31:0] wr_col, wr_row, view_top, cursor_q;

    tcs_pkg::result_t expected_results [$];
    int  errors = 0;
    int  stall_cnt = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    text_console_scrollback_core uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always #2 clk = ~clk;

    function automatic void console_reset();
        foreach (sb_mem[i]) sb_mem[i] = tcs_pkg::BLANK_CELL;
        foreach (scr_mem[i]) scr_mem[i] = tcs_pkg::BLANK_CELL;
        wr_col = 0;
        wr_row = 0;
        view_top = 0;
        cursor_q = 0;
    endfunction

    function automatic void console_put(logic [7:0] ch, logic [7:0] attr);
        if (ch == tcs_pkg::CH_BS && wr_col != 0)
            wr_col = wr_col - 1;
        else if (ch == tcs_pkg::CH_TAB)
            wr_col = (wr_col + tcs_pkg::TAB_STOP) & ~(tcs_pkg::TAB_STOP - 1);
        else if (ch == tcs_pkg::CH_CR)
            wr_col = 0;
        else if (ch == tcs_pkg::CH_LF)
        begin
            wr_col = 0;
            wr_row = wr_row + 1;
        end
        else if (ch >= tcs_pkg::CH_FIRST && ch <= tcs_pkg::CH_LAST)
        begin
            if (wr_col < COLS && wr_row < BUFFER_ROWS)
                sb_mem[wr_row*COLS + wr_col] = {attr, ch};
            wr_col = wr_col + 1;
        end
        if (wr_col >= COLS)
        begin
            wr_col = 0;
            wr_row = wr_row + 1;
        end
        if (wr_row >= BUFFER_ROWS - 1)
        begin
            for (int i = 0; i < (BUFFER_ROWS-1)*COLS; i++)
                sb_mem[i] = sb_mem[i + COLS];
            for (int i = (BUFFER_ROWS-1)*COLS; i < BUFFER_ROWS*COLS; i++)
                sb_mem[i] = tcs_pkg::BLANK_CELL;
            wr_row = BUFFER_ROWS - 2;
        end
    endfunction

    function automatic void console_refresh();
        logic [31:0] rows;
        logic [31:0] cells;
        rows = 0;
        if (view_top <= wr_row)
            rows = wr_row + 1 - view_top;
        if (rows > SCREEN_ROWS)
            rows = SCREEN_ROWS;
        if (view_top + rows > BUFFER_ROWS)
            rows = (view_top < BUFFER_ROWS) ? BUFFER_ROWS - view_top : 0;
        cells = rows * COLS;
        for (int i = 0; i < SCREEN_ROWS*COLS; i++)
            scr_mem[i] = (i < cells) ? sb_mem[view_top*COLS + i] : tcs_pkg::BLANK_CELL;
        cursor_q = ((wr_row - view_top) * COLS + wr_col) & 32'h3FFF;
    endfunction

    function automatic tcs_pkg::result_t console_step(tcs_pkg::item_t it);
        tcs_pkg::result_t r;
        logic [15:0] rd_cell;
        rd_cell = '0;
        case (it.func)
            tcs_pkg::FUNC_PUT: console_put(it.char_code, {it.bg_color, it.fg_color});
            tcs_pkg::FUNC_FOLLOW:
            begin
                view_top = (wr_row >= SCREEN_ROWS - 1) ? wr_row - (SCREEN_ROWS - 1) : 0;
                console_refresh();
            end
            tcs_pkg::FUNC_UP:
            begin
                view_top = (view_top >= it.line_offset) ? view_top - it.line_offset : 0;
                console_refresh();
            end
            tcs_pkg::FUNC_DOWN:
            begin
                view_top = (view_top + it.line_offset < wr_row) ?
                           view_top + it.line_offset : wr_row;
                console_refresh();
            end
            tcs_pkg::FUNC_READ:
                if (it.cell_index < SCREEN_ROWS*COLS)
                    rd_cell = scr_mem[it.cell_index];
            default: ;
        endcase
        r.cell_value      = rd_cell;
        r.cursor_position = cursor_q[13:0];
        r.view_top_line   = view_top[6:0];
        return r;
    endfunction

    task automatic send_beat(tcs_pkg::item_t it);
        int gap;
        if (!no_idle && $urandom_range(99) < 21)
        begin
            item_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        expected_results.push_back(console_step(it));
    endtask

    function automatic tcs_pkg::item_t make_item(logic [2:0] f, logic [7:0] ch);
        tcs_pkg::item_t it;
        it.func        = f;
        it.char_code   = ch;
        it.bg_color    = 4'($urandom_range(15));
        it.fg_color    = 4'($urandom_range(15));
        it.line_offset = 16'($urandom_range(65535));
        it.cell_index  = 11'($urandom_range(2047));
        return it;
    endfunction

    function automatic tcs_pkg::item_t random_item();
        int p;
        tcs_pkg::item_t it;
        p = $urandom_range(99);
        it = make_item(tcs_pkg::FUNC_PUT,
                       8'($urandom_range(tcs_pkg::CH_FIRST, tcs_pkg::CH_LAST)));
        if (p < 60)
        begin
            p = $urandom_range(99);
            if (p < 40)
                it.char_code = tcs_pkg::CH_LF;
            else if (p < 50)
                it.char_code = ($urandom_range(2) == 0) ? tcs_pkg::CH_BS :
                               ($urandom_range(1) == 0) ? tcs_pkg::CH_TAB : tcs_pkg::CH_CR;
            else if (p < 85)
                it.char_code = 8'($urandom_range(tcs_pkg::CH_FIRST, tcs_pkg::CH_LAST));
            else
                it.char_code = 8'($urandom_range(255));
        end
        else if (p < 65)
            it.func = tcs_pkg::FUNC_FOLLOW;
        else if (p < 69)
        begin
            it.func = tcs_pkg::FUNC_UP;
            if ($urandom_range(1)) it.line_offset = 16'($urandom_range(40));
        end
        else if (p < 73)
        begin
            it.func = tcs_pkg::FUNC_DOWN;
            if ($urandom_range(1)) it.line_offset = 16'($urandom_range(40));
        end
        else if (p < 97)
        begin
            it.func = tcs_pkg::FUNC_READ;
            if ($urandom_range(3) != 0)
                it.cell_index = 11'($urandom_range(SCREEN_ROWS*COLS-1));
        end
        else
            it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        return it;
    endfunction

    task automatic test_directed();
        tcs_pkg::item_t it;
        logic [10:0] idx_list [6];
        idx_list = '{11'd0, 11'd1, 11'd80, 11'd1999, 11'd2000, 11'd2047};
        it = make_item(tcs_pkg::FUNC_PUT, "A");
        it.bg_color = 4'h0; it.fg_color = 4'hF;
        send_beat(it);
        it.char_code = "Z"; it.bg_color = 4'hF; it.fg_color = 4'h0;
        send_beat(it);
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_FIRST));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_LAST));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_TAB));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_BS));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_CR));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_BS));
        send_beat(make_item(tcs_pkg::FUNC_PUT, 8'h00));
        send_beat(make_item(tcs_pkg::FUNC_PUT, 8'hFF));
        send_beat(make_item(tcs_pkg::FUNC_PUT, 8'h80));
        send_beat(make_item(tcs_pkg::FUNC_PUT, tcs_pkg::CH_LF));
        send_beat(make_item(tcs_pkg::FUNC_PUT, "q"));
        send_beat(make_item(tcs_pkg::FUNC_FOLLOW, 8'h00));
        it = make_item(tcs_pkg::FUNC_READ, 8'h00);
        foreach (idx_list[k])
        begin
            it.cell_index = idx_list[k];
            send_beat(it);
        end
        it = make_item(tcs_pkg::FUNC_UP, 8'h00);
        it.line_offset = 16'd0; send_beat(it);
        it.line_offset = 16'hFFFF; send_beat(it);
        it.func = tcs_pkg::FUNC_DOWN; send_beat(it);
        it.line_offset = 16'd0; send_beat(it);
        send_beat(make_item(FUNC_SPARE_LO, 8'h41));
        send_beat(make_item(FUNC_SPARE_HI, 8'h41));
    endtask

    task automatic test_backpressure();
        tcs_pkg::item_t it;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            it = make_item((i % 3 == 0) ? tcs_pkg::FUNC_PUT : tcs_pkg::FUNC_READ,
                           8'($urandom_range(tcs_pkg::CH_FIRST, tcs_pkg::CH_LAST)));
            send_beat(it);
        end
    endtask

    task automatic test_sender_pause();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        send_beat(make_item(tcs_pkg::FUNC_FOLLOW, 8'h00));
        send_beat(make_item(tcs_pkg::FUNC_READ, 8'h00));
    endtask

    task automatic test_random();
        for (int i = 0; i < 600; i++)
        begin
            no_idle = (i >= 250 && i < 330);
            send_beat(random_item());
        end
        no_idle = 1'b0;
        item_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        tcs_pkg::result_t want;
        if (result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.cell_value !== want.cell_value ||
                    result.cursor_position !== want.cursor_position ||
                    result.view_top_line !== want.view_top_line)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: cell %h/%h cursor %0d/%0d top %0d/%0d (exp/act)",
                                 want.cell_value, result.cell_value,
                                 want.cursor_position, result.cursor_position,
                                 want.view_top_line, result.view_top_line);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        console_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
rtl/tcs_pkg.sv
rtl/tcs_addr_unit.sv
rtl/tcs_ram.sv
rtl/tcs_ctrl.sv
rtl/text_console_scrollback_core.sv
rtl/tcs_checker.sv
verif/testbench.sv
